// ===== rtl/pgsa_pkg.sv =====
// Shared types, codes and helper functions for the passkey gated safety alarm.
package pgsa_pkg;

  localparam int PASSKEY_LENGTH_DEF = 4;
  localparam int QUEUE_DEPTH        = 2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [1:0] REG_PASSKEY_CODES   = 2'd0;
  localparam logic [1:0] REG_GAS_LEVEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_HOT_ADC_LIMIT   = 2'd2;

  localparam logic [15:0] PASSKEY_CODES_RST   = 16'h4210;
  localparam logic [6:0]  GAS_LEVEL_LIMIT_RST = 7'd20;
  localparam logic [11:0] HOT_ADC_LIMIT_RST   = 12'd1997;

  localparam logic [3:0] KEY_STAR = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd14;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_STORED  = 3'd1;
  localparam logic [2:0] EV_CLEARED = 3'd2;
  localparam logic [2:0] EV_GRANTED = 3'd3;
  localparam logic [2:0] EV_DENIED  = 3'd4;

  localparam logic [2:0] MSG_GAS_MONITOR = 3'd0;
  localparam logic [2:0] MSG_FIRE_SMOKE  = 3'd1;
  localparam logic [2:0] MSG_FIRE        = 3'd2;
  localparam logic [2:0] MSG_SMOKE       = 3'd3;
  localparam logic [2:0] MSG_SAFE        = 3'd4;

  // One gas level step in converter counts
  localparam logic [12:0] GAS_STEP = 13'd41;

  typedef struct packed {
    logic        authorized;
    logic [2:0]  entry_event;
    logic [2:0]  entered_count;
    logic        evaluate;
    logic [11:0] gas_sample;
    logic        flame_seen;
    logic [11:0] temp_sample;
  } op_t;

  typedef struct packed {
    logic [2:0] message;
    logic       fan_drive;
    logic       pump_drive;
    logic       green_lamp;
    logic       yellow_lamp;
    logic       red_lamp;
    logic       buzzer;
  } alarm_t;

  function automatic logic [3:0] passkey_nibble(input logic [15:0] codes, input int idx);
    logic [3:0] nib;
    unique case (idx)
      0:       nib = codes[3:0];
      1:       nib = codes[7:4];
      2:       nib = codes[11:8];
      3:       nib = codes[15:12];
      default: nib = 4'd0;
    endcase
    return nib;
  endfunction

  // floor(sample * 6 / 4100) as a count of crossed thresholds
  function automatic logic [2:0] bar_level_of(input logic [11:0] sample);
    logic [2:0] lvl;
    lvl = 3'd0;
    if (sample >= 12'd684)  lvl = 3'd1;
    if (sample >= 12'd1367) lvl = 3'd2;
    if (sample >= 12'd2050) lvl = 3'd3;
    if (sample >= 12'd2734) lvl = 3'd4;
    if (sample >= 12'd3417) lvl = 3'd5;
    return lvl;
  endfunction

endpackage

// ===== rtl/pgsa_front.sv =====
// Front end: accepts requests, runs passkey entry and classifies each request.
module pgsa_front #(
  parameter int PASSKEY_LENGTH = pgsa_pkg::PASSKEY_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [3:0] key_code, [15:4] gas_sample, [16] flame_seen, [28:17] temp_sample
  input  logic [pgsa_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] mode
  input  logic                           s_tuser,
  input  logic [15:0]                    passkey_codes,
  input  logic                           q_full,
  output logic                           push,
  output pgsa_pkg::op_t                  op
);
  import pgsa_pkg::*;

  localparam int CNT_W = $clog2(PASSKEY_LENGTH + 1);
  localparam int IDX_W = (PASSKEY_LENGTH > 1) ? $clog2(PASSKEY_LENGTH) : 1;

  logic [3:0]       entry_keys [PASSKEY_LENGTH];
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             access_granted, access_granted_next;
  logic             match;
  logic             store;
  logic [2:0]       event_code;
  logic [3:0]       key_code;

  assign key_code = s_tdata[3:0];
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    match = (entry_count == CNT_W'(PASSKEY_LENGTH));
    for (int i = 0; i < PASSKEY_LENGTH; i++) begin
      if (entry_keys[i] != passkey_nibble(passkey_codes, i)) match = 1'b0;
    end
  end

  always_comb begin
    event_code          = EV_NONE;
    entry_count_next    = entry_count;
    access_granted_next = access_granted;
    store               = 1'b0;
    if (!s_tuser) begin
      if (key_code == KEY_STAR) begin
        event_code       = EV_CLEARED;
        entry_count_next = '0;
      end else if (key_code == KEY_HASH && entry_count != '0) begin
        entry_count_next = '0;
        if (match) begin
          event_code          = EV_GRANTED;
          access_granted_next = 1'b1;
        end else begin
          event_code = EV_DENIED;
        end
      end else if (entry_count < CNT_W'(PASSKEY_LENGTH)) begin
        event_code       = EV_STORED;
        store            = 1'b1;
        entry_count_next = entry_count + 1'b1;
      end
    end
  end

  always_comb begin
    op.authorized    = access_granted_next;
    op.entry_event   = event_code;
    op.entered_count = 3'(entry_count_next);
    op.evaluate      = s_tuser && access_granted;
    op.gas_sample    = s_tdata[15:4];
    op.flame_seen    = s_tdata[16];
    op.temp_sample   = s_tdata[28:17];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      access_granted <= 1'b0;
    end else if (push) begin
      entry_count    <= entry_count_next;
      access_granted <= access_granted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && store) begin
      entry_keys[entry_count[IDX_W-1:0]] <= key_code;
    end
  end

endmodule

// ===== rtl/pgsa_queue.sv =====
// Short first-in first-out queue of classified requests between front and back.
module pgsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pgsa_pkg::op_t push_data,
  input  logic          pop,
  output pgsa_pkg::op_t pop_data,
  output logic          full,
  output logic          empty
);
  import pgsa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/pgsa_back.sv =====
// Back end: applies requests to the alarm drives and bar graph, holds the result.
module pgsa_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  pgsa_pkg::op_t                   q_data,
  output logic                            pop,
  input  logic [6:0]                      gas_level_limit,
  input  logic [11:0]                     hot_adc_limit,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] authorized, [3:1] entry_event, [6:4] entered_count, [7] buzzer,
  // [8] red_lamp, [9] yellow_lamp, [10] green_lamp, [11] pump_drive,
  // [12] fan_drive, [15:13] message, [18:16] bar_level
  output logic [pgsa_pkg::OUT_DATA_W-1:0] m_tdata
);
  import pgsa_pkg::*;

  alarm_t      alarm, alarm_next, drv;
  logic [2:0]  bar, bar_next;
  logic [12:0] thr_high, thr_low;
  logic        gas_high, gas_low, hot;
  logic [OUT_DATA_W-1:0] out_data;

  assign pop     = !q_empty && (!m_tvalid || m_tready);
  assign m_tdata = out_data;

  // gas/41 > limit  <=>  sample >= 41*(limit+1); gas/41 < limit <=> sample < 41*limit
  assign thr_high = ({6'd0, gas_level_limit} + 13'd1) * GAS_STEP;
  assign thr_low  = {6'd0, gas_level_limit} * GAS_STEP;
  assign gas_high = {1'b0, q_data.gas_sample} >= thr_high;
  assign gas_low  = {1'b0, q_data.gas_sample} < thr_low;
  assign hot      = q_data.temp_sample <= hot_adc_limit;

  always_comb begin
    drv        = '0;
    alarm_next = alarm;
    bar_next   = bar;
    if (q_data.evaluate) begin
      if (q_data.flame_seen) begin
        drv.buzzer     = 1'b1;
        drv.red_lamp   = 1'b1;
        drv.pump_drive = 1'b1;
      end
      if (hot) begin
        drv.buzzer      = 1'b1;
        drv.yellow_lamp = 1'b1;
        drv.fan_drive   = 1'b1;
      end
      if (gas_high) begin
        drv.message = MSG_GAS_MONITOR;
        bar_next    = bar_level_of(q_data.gas_sample);
      end else if (gas_low && (q_data.flame_seen || hot)) begin
        drv.message = q_data.flame_seen ? (hot ? MSG_FIRE_SMOKE : MSG_FIRE) : MSG_SMOKE;
      end else begin
        drv            = '0;
        drv.green_lamp = 1'b1;
        drv.message    = MSG_SAFE;
      end
      alarm_next = drv;
    end else if (q_data.entry_event == EV_DENIED) begin
      alarm_next.red_lamp = 1'b1;
    end else if (q_data.entry_event == EV_GRANTED) begin
      alarm_next.red_lamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm    <= '0;
      bar      <= '0;
      m_tvalid <= 1'b0;
    end else if (pop) begin
      alarm    <= alarm_next;
      bar      <= bar_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {5'd0, bar_next, alarm_next.message, alarm_next.fan_drive,
                   alarm_next.pump_drive, alarm_next.green_lamp, alarm_next.yellow_lamp,
                   alarm_next.red_lamp, alarm_next.buzzer, q_data.entered_count,
                   q_data.entry_event, q_data.authorized};
    end
  end

endmodule

// ===== rtl/passkey_gated_safety_alarm.sv =====
// Passkey gated gas, flame and temperature alarm: top level.
//
// Requests enter on the s_ stream: s_tuser low carries a keypad press, high a
// sensor sample. Each request yields exactly one result on the m_ stream with
// the access flag, the entry event, the keys held and the current alarm drives.
// Sensor samples change nothing until a correct passkey followed by hash has
// been entered.
// The cfg_ channel writes the passkey codes (index 0), the gas level limit
// (index 1) and the hot temperature count limit (index 2); cfg_ready is always
// high and writes take effect on the next cycle.
// On its way to a result a request is registered in the two-entry request
// queue behind the front end, then in the back end's output register.
// Throughput is one request per cycle while m_tready is high; the passkey
// compare and the gas and temperature threshold compares are combinational.
// When the receiver stalls, the result holds in the output register, the
// queue fills and s_tready drops once it is full.
// Reset clears the entered key count, access, all drives, the message and the bar
// level, and reloads the register reset values.
module passkey_gated_safety_alarm #(
  parameter int PASSKEY_LENGTH = pgsa_pkg::PASSKEY_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] key_code, [15:4] gas_sample, [16] flame_seen, [28:17] temp_sample
  input  logic [pgsa_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] mode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] authorized, [3:1] entry_event, [6:4] entered_count, [7] buzzer,
  // [8] red_lamp, [9] yellow_lamp, [10] green_lamp, [11] pump_drive,
  // [12] fan_drive, [15:13] message, [18:16] bar_level
  output logic [pgsa_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data
);
  import pgsa_pkg::*;

  logic [15:0] passkey_codes;
  logic [6:0]  gas_level_limit;
  logic [11:0] hot_adc_limit;
  logic        push, pop, q_full, q_empty;
  op_t         push_op, pop_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      passkey_codes   <= PASSKEY_CODES_RST;
      gas_level_limit <= GAS_LEVEL_LIMIT_RST;
      hot_adc_limit   <= HOT_ADC_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PASSKEY_CODES:   passkey_codes   <= cfg_data;
        REG_GAS_LEVEL_LIMIT: gas_level_limit <= cfg_data[6:0];
        REG_HOT_ADC_LIMIT:   hot_adc_limit   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  pgsa_front #(
    .PASSKEY_LENGTH(PASSKEY_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .passkey_codes (passkey_codes),
    .q_full        (q_full),
    .push          (push),
    .op            (push_op)
  );

  pgsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_op),
    .pop       (pop),
    .pop_data  (pop_op),
    .full      (q_full),
    .empty     (q_empty)
  );

  pgsa_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (pop_op),
    .pop             (pop),
    .gas_level_limit (gas_level_limit),
    .hot_adc_limit   (hot_adc_limit),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("back end popped an empty request queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_empty)
    else $error("request queue full and empty at once");

  a_hot_drives: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> (m_tdata[7] && m_tdata[12]))
    else $error("yellow lamp lit without buzzer and fan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[6:4]) <= PASSKEY_LENGTH))
    else $error("entered count above passkey length");

endmodule
